FILE: rtl/bscf_pkg.sv
// shared constants, codes and types of the bitmap set / clear / find-first block
package bscf_pkg;

  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = 64;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TOTAL_BITS = NUM_WORDS * WORD_BITS;

  localparam int MODE_W = 3;
  localparam int POS_W  = 12;
  localparam int IDX_W  = 13;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic CFG_REG_BITS_IN_USE = 1'b0;
  localparam logic [IDX_W-1:0] BITS_IN_USE_RST = IDX_W'(4096);

  typedef enum logic [MODE_W-1:0] {
    MODE_SET       = 3'd0,
    MODE_CLEAR     = 3'd1,
    MODE_TEST      = 3'd2,
    MODE_FIND_ZERO = 3'd3,
    MODE_FIND_ONE  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             bit_value;
    logic [IDX_W-1:0] found_index;
    logic             found;
  } result_t;

endpackage

FILE: rtl/bscf_in_if.sv
// request channel: mode and bit position
interface bscf_in_if;
  logic                         valid;
  logic                         ready;
  logic [bscf_pkg::MODE_W-1:0] mode;
  logic [bscf_pkg::POS_W-1:0]  position;

  modport source(output valid, mode, position, input ready);
  modport sink(input valid, mode, position, output ready);
endinterface

FILE: rtl/bscf_out_if.sv
// result channel: tested bit, found index and found flag
interface bscf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        bit_value;
  logic [bscf_pkg::IDX_W-1:0] found_index;
  logic                        found;

  modport source(output valid, bit_value, found_index, found, input ready);
  modport sink(input valid, bit_value, found_index, found, output ready);
endinterface

FILE: rtl/bitmap_set_clear_find_first.sv
// top level: 4096-bit bitmap with set, clear, test and find-first searches
//
// in_word carries mode and position; out_word returns one word per request
// (bit_value, found_index, found). both use valid/ready, a word moves when
// both are high. bits_in_use is written over the apb-style cfg_ port at
// byte address 0 and limits the searches.
// set, clear and test run a ram read, then the read-modify-write, then
// the output load.
// a search reads one bitmap word per cycle from the single read port and
// checks it in the following cycle; it ends at the first word with a hit or after
// the last covered word, and with bits_in_use zero it goes straight to the
// output without reading the bitmap. in_word.ready rises in the same cycle
// as out valid at the earliest.
// one request is in flight at a time; in_word.ready is high only when the
// sequencer is idle. the output register lets the next request start
// while a result waits; a stalled receiver holds the finished result in
// the sequencer until the output register frees up.
// reset clears all row valid flags, so the whole bitmap reads as zero at
// once, and sets bits_in_use to 4096.
module bitmap_set_clear_find_first (
  input  logic                          clk,
  input  logic                          rst_n,
  bscf_in_if.sink                       in_word,
  bscf_out_if.source                    out_word,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bscf_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [bscf_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [bscf_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  bscf_pkg::state_t                   state_r, state_nxt;
  logic [bscf_pkg::MODE_W-1:0]        mode_r;
  logic [bscf_pkg::POS_W-1:0]         pos_r;
  logic [bscf_pkg::IDX_W-1:0]         bits_in_use_r;
  logic [bscf_pkg::NUM_WORDS-1:0]     vld_r;
  logic                               rd_vld_r;
  logic [bscf_pkg::WADDR_W-1:0]       addr_r, addr_nxt;
  logic                               addr_done_r, addr_done_nxt;
  logic                               eval_v_r, eval_v_nxt;
  logic [bscf_pkg::WADDR_W-1:0]       eval_w_r, eval_w_nxt;
  bscf_pkg::result_t                  res_r, res_nxt;
  logic                               out_v_r, out_v_nxt;
  bscf_pkg::result_t                  out_res_r, out_res_nxt;

  logic                               in_acc;
  logic                               out_load;
  logic                               cfg_wr;
  logic [bscf_pkg::IDX_W-1:0]         n_eff;
  logic [bscf_pkg::IDX_W-1:0]         n_eff_m1;
  logic [bscf_pkg::WADDR_W-1:0]       last_w;
  logic [bscf_pkg::WORD_BITS-1:0]     scan_mask;
  logic                               pos_in_range;
  logic [bscf_pkg::BIT_W-1:0]         pos_bit;

  logic                               ram_we;
  logic [bscf_pkg::WADDR_W-1:0]       ram_waddr;
  logic [bscf_pkg::WORD_BITS-1:0]     ram_wdata;
  logic                               ram_re;
  logic [bscf_pkg::WADDR_W-1:0]       ram_raddr;
  logic [bscf_pkg::WORD_BITS-1:0]     ram_q;
  logic [bscf_pkg::WORD_BITS-1:0]     word_q;

  logic                               find_hit;
  logic [bscf_pkg::BIT_W-1:0]         find_bit;
  logic                               find_target;
  logic                               scan_finish;

  bscf_ram #(
    .WIDTH(bscf_pkg::WORD_BITS),
    .DEPTH(bscf_pkg::NUM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  bscf_word_find u_find (
    .data   (word_q),
    .mask   (scan_mask),
    .target (find_target),
    .hit    (find_hit),
    .bit_idx(find_bit)
  );

  assign in_word.ready = (state_r == bscf_pkg::ST_IDLE);
  assign in_acc        = in_word.valid && in_word.ready;
  assign out_load      = (state_r == bscf_pkg::ST_DONE) && (!out_v_r || out_word.ready);

  assign out_word.valid       = out_v_r;
  assign out_word.bit_value   = out_res_r.bit_value;
  assign out_word.found_index = out_res_r.found_index;
  assign out_word.found       = out_res_r.found;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == bscf_pkg::CFG_REG_BITS_IN_USE);
  assign cfg_prdata = (cfg_paddr[2] == bscf_pkg::CFG_REG_BITS_IN_USE)
                      ? bscf_pkg::CFG_DW'(bits_in_use_r) : '0;

  // covered range, clipped to the bitmap size
  assign n_eff    = (bits_in_use_r > bscf_pkg::IDX_W'(bscf_pkg::TOTAL_BITS))
                    ? bscf_pkg::IDX_W'(bscf_pkg::TOTAL_BITS) : bits_in_use_r;
  assign n_eff_m1 = n_eff - bscf_pkg::IDX_W'(1);
  assign last_w   = n_eff_m1[bscf_pkg::BIT_W +: bscf_pkg::WADDR_W];

  always_comb begin
    scan_mask = '1;
    if ((eval_w_r == last_w) && (n_eff[bscf_pkg::BIT_W-1:0] != '0)) begin
      scan_mask = (bscf_pkg::WORD_BITS'(1) << n_eff[bscf_pkg::BIT_W-1:0])
                  - bscf_pkg::WORD_BITS'(1);
    end
  end

  assign word_q       = rd_vld_r ? ram_q : '0;
  assign find_target  = (mode_r == bscf_pkg::MODE_FIND_ONE);
  assign pos_bit      = pos_r[bscf_pkg::BIT_W-1:0];
  assign pos_in_range = ({1'b0, pos_r[bscf_pkg::POS_W-1:bscf_pkg::BIT_W]}
                         < (bscf_pkg::POS_W - bscf_pkg::BIT_W + 1)'(bscf_pkg::NUM_WORDS));
  assign scan_finish  = (state_r == bscf_pkg::ST_SCAN) && eval_v_r
                        && (find_hit || (eval_w_r == last_w));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bscf_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_word.mode) inside
            bscf_pkg::MODE_SET, bscf_pkg::MODE_CLEAR, bscf_pkg::MODE_TEST:
              state_nxt = bscf_pkg::ST_RMW_RD;
            bscf_pkg::MODE_FIND_ZERO, bscf_pkg::MODE_FIND_ONE:
              state_nxt = (n_eff == '0) ? bscf_pkg::ST_DONE : bscf_pkg::ST_SCAN;
            default:
              state_nxt = bscf_pkg::ST_DONE;
          endcase
        end
      end
      bscf_pkg::ST_RMW_RD: state_nxt = bscf_pkg::ST_RMW_WR;
      bscf_pkg::ST_RMW_WR: state_nxt = bscf_pkg::ST_DONE;
      bscf_pkg::ST_SCAN: begin
        if (scan_finish) begin
          state_nxt = bscf_pkg::ST_DONE;
        end
      end
      bscf_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = bscf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bscf_pkg::ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    res_nxt       = res_r;
    addr_nxt      = addr_r;
    addr_done_nxt = addr_done_r;
    eval_v_nxt    = 1'b0;
    eval_w_nxt    = eval_w_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r[bscf_pkg::BIT_W +: bscf_pkg::WADDR_W];
    ram_wdata     = word_q;
    ram_re        = 1'b0;
    ram_raddr     = addr_r;
    out_v_nxt     = out_v_r && !out_word.ready;
    out_res_nxt   = out_res_r;

    unique case (state_r)
      bscf_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_nxt       = '0;
          addr_nxt      = '0;
          addr_done_nxt = 1'b0;
          if ((in_word.mode == bscf_pkg::MODE_FIND_ZERO
               || in_word.mode == bscf_pkg::MODE_FIND_ONE) && (n_eff == '0)) begin
            res_nxt.found_index = bscf_pkg::IDX_W'(1);
          end
        end
      end
      bscf_pkg::ST_RMW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_r[bscf_pkg::BIT_W +: bscf_pkg::WADDR_W];
      end
      bscf_pkg::ST_RMW_WR: begin
        if (pos_in_range) begin
          case (mode_r)
            bscf_pkg::MODE_SET: begin
              ram_we    = 1'b1;
              ram_wdata = word_q | (bscf_pkg::WORD_BITS'(1) << pos_bit);
            end
            bscf_pkg::MODE_CLEAR: begin
              ram_we    = 1'b1;
              ram_wdata = word_q & ~(bscf_pkg::WORD_BITS'(1) << pos_bit);
            end
            default: res_nxt.bit_value = word_q[pos_bit];
          endcase
        end
      end
      bscf_pkg::ST_SCAN: begin
        // read one word per cycle, evaluate the word read in the previous cycle
        if (!addr_done_r && !scan_finish) begin
          ram_re     = 1'b1;
          eval_v_nxt = 1'b1;
          eval_w_nxt = addr_r;
          if (addr_r == last_w) begin
            addr_done_nxt = 1'b1;
          end else begin
            addr_nxt = addr_r + bscf_pkg::WADDR_W'(1);
          end
        end
        if (scan_finish) begin
          if (find_hit) begin
            res_nxt.found_index = bscf_pkg::IDX_W'({eval_w_r, find_bit});
            res_nxt.found       = 1'b1;
          end else begin
            res_nxt.found_index = n_eff + bscf_pkg::IDX_W'(1);
            res_nxt.found       = 1'b0;
          end
        end
      end
      bscf_pkg::ST_DONE: begin
        if (out_load) begin
          out_v_nxt   = 1'b1;
          out_res_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bscf_pkg::ST_IDLE;
      bits_in_use_r <= bscf_pkg::BITS_IN_USE_RST;
      vld_r         <= '0;
      addr_done_r   <= 1'b0;
      eval_v_r      <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_done_r <= addr_done_nxt;
      eval_v_r    <= eval_v_nxt;
      out_v_r     <= out_v_nxt;
      if (cfg_wr) begin
        bits_in_use_r <= cfg_pwdata[bscf_pkg::IDX_W-1:0];
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_word.mode;
      pos_r  <= in_word.position;
    end
    if (ram_re) begin
      rd_vld_r <= vld_r[ram_raddr];
    end
    addr_r    <= addr_nxt;
    eval_w_r  <= eval_w_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

`ifndef ASSERT_OFF
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bscf_pkg::ST_SCAN) && eval_v_r |-> eval_w_r <= last_w)
    else $error("scan evaluates a word beyond the covered range");

  a_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> vld_r[$past(ram_waddr)])
    else $error("written row not marked valid");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_v_r && (state_r == bscf_pkg::ST_IDLE))
    else $error("finished result not moved to output register");
`endif

endmodule

FILE: rtl/bscf_ram.sv
// generic single write port, single read port ram with registered read
module bscf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/bscf_word_find.sv
// lowest matching bit of one bitmap word under a range mask
module bscf_word_find (
  input  logic [bscf_pkg::WORD_BITS-1:0] data,
  input  logic [bscf_pkg::WORD_BITS-1:0] mask,
  input  logic                           target,
  output logic                           hit,
  output logic [bscf_pkg::BIT_W-1:0]     bit_idx
);

  logic [bscf_pkg::WORD_BITS-1:0] cand;

  assign cand = (target ? data : ~data) & mask;
  assign hit  = |cand;

  always_comb begin
    bit_idx = '0;
    for (int i = bscf_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        bit_idx = bscf_pkg::BIT_W'(i);
      end
    end
  end

endmodule

FILE: tb/bitmap_set_clear_find_first_tb.sv
// testbench for the bitmap set / clear / test / find-first block: directed table, then random
module bitmap_set_clear_find_first_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 8;
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 138;
  localparam int N_DIR        = 29;

  localparam logic [bscf_pkg::MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [bscf_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [bscf_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;

  localparam logic [bscf_pkg::CFG_AW-1:0] BITS_IN_USE_ADDR =
    bscf_pkg::CFG_AW'(4 * bscf_pkg::CFG_REG_BITS_IN_USE);

  typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [bscf_pkg::MODE_W-1:0] mode;
    logic [bscf_pkg::POS_W-1:0]  pos;
    logic [bscf_pkg::IDX_W-1:0]  span;
    bit                          exact;
    logic                        want_bit;
    logic [bscf_pkg::IDX_W-1:0]  want_idx;
    logic                        want_found;
  } dir_row_t;

  // kind, mode, position, span, exact, bit_value, found_index, found
  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_REQ, bscf_pkg::MODE_FIND_ONE,  12'd0,    13'd0,    1'b1, 1'b0, 13'd4097, 1'b0},
    '{ROW_REQ, bscf_pkg::MODE_FIND_ZERO, 12'd0,    13'd0,    1'b1, 1'b0, 13'd0,    1'b1},
    '{ROW_REQ, bscf_pkg::MODE_TEST,      12'd4095, 13'd0,    1'b1, 1'b0, 13'd0,    1'b0},
    '{ROW_CFG, bscf_pkg::MODE_SET,       12'd0,    13'd8191, 1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_FIND_ONE,  12'd0,    13'd0,    1'b1, 1'b0, 13'd4097, 1'b0},
    '{ROW_CFG, bscf_pkg::MODE_SET,       12'd0,    13'd0,    1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_FIND_ZERO, 12'd4095, 13'd0,    1'b1, 1'b0, 13'd1,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_FIND_ONE,  12'd0,    13'd0,    1'b1, 1'b0, 13'd1,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_SET,       12'd0,    13'd0,    1'b1, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_SET,       12'd4095, 13'd0,    1'b1, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_TEST,      12'd4095, 13'd0,    1'b1, 1'b1, 13'd0,    1'b0},
    '{ROW_CFG, bscf_pkg::MODE_SET,       12'd0,    13'd1,    1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_FIND_ZERO, 12'd0,    13'd0,    1'b1, 1'b0, 13'd2,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_FIND_ONE,  12'd0,    13'd0,    1'b1, 1'b0, 13'd0,    1'b1},
    '{ROW_CFG, bscf_pkg::MODE_SET,       12'd0,    13'd4096, 1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_SET,       12'd63,   13'd0,    1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_SET,       12'd64,   13'd0,    1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_CLEAR,     12'd0,    13'd0,    1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_FIND_ONE,  12'd0,    13'd0,    1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_FIND_ZERO, 12'd0,    13'd0,    1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_TEST,      12'd64,   13'd0,    1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, MODE_RSVD5,               12'd4095, 13'd0,    1'b1, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, MODE_RSVD6,               12'd2048, 13'd0,    1'b1, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, MODE_RSVD7,               12'd0,    13'd0,    1'b1, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_CLEAR,     12'd4095, 13'd0,    1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_TEST,      12'd4095, 13'd0,    1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_CFG, bscf_pkg::MODE_SET,       12'd0,    13'd65,   1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_FIND_ONE,  12'd0,    13'd0,    1'b0, 1'b0, 13'd0,    1'b0},
    '{ROW_REQ, bscf_pkg::MODE_FIND_ZERO, 12'd0,    13'd0,    1'b0, 1'b0, 13'd0,    1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [bscf_pkg::CFG_AW-1:0] cfg_paddr;
  logic [bscf_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [bscf_pkg::CFG_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  bscf_in_if  in_ch();
  bscf_out_if out_ch();

  bitmap_set_clear_find_first dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_ch),
    .out_word   (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [bscf_pkg::WORD_BITS-1:0] bmap_words [bscf_pkg::NUM_WORDS];
  logic [bscf_pkg::IDX_W-1:0]     span_reg;
  bscf_pkg::result_t              pending_results [$];
  int                             mismatches = 0;
  int                             idle_cycles = 0;
  bit                             send_idle;
  bit                             recv_idle;
  int                             long_hold_reqs = 0;
  bit                             draining;

  function automatic int covered_len();
    return (span_reg > bscf_pkg::TOTAL_BITS) ? bscf_pkg::TOTAL_BITS : int'(span_reg);
  endfunction

  function automatic int lowest_match(logic target);
    int n;
    n = covered_len();
    for (int k = 0; k < n; k++) begin
      if (bmap_words[k / bscf_pkg::WORD_BITS][k % bscf_pkg::WORD_BITS] == target) return k;
    end
    return -1;
  endfunction

  function automatic bscf_pkg::result_t predict_bitmap_op(logic [bscf_pkg::MODE_W-1:0] mode,
                                                          logic [bscf_pkg::POS_W-1:0] pos);
    bscf_pkg::result_t r;
    int                hit;
    r = '0;
    case (mode) inside
      bscf_pkg::MODE_SET:
        bmap_words[pos / bscf_pkg::WORD_BITS][pos % bscf_pkg::WORD_BITS] = 1'b1;
      bscf_pkg::MODE_CLEAR:
        bmap_words[pos / bscf_pkg::WORD_BITS][pos % bscf_pkg::WORD_BITS] = 1'b0;
      bscf_pkg::MODE_TEST:
        r.bit_value = bmap_words[pos / bscf_pkg::WORD_BITS][pos % bscf_pkg::WORD_BITS];
      bscf_pkg::MODE_FIND_ZERO, bscf_pkg::MODE_FIND_ONE: begin
        hit = lowest_match(mode == bscf_pkg::MODE_FIND_ONE);
        if (hit >= 0) begin
          r.found_index = bscf_pkg::IDX_W'(hit);
          r.found       = 1'b1;
        end else begin
          r.found_index = bscf_pkg::IDX_W'(covered_len() + 1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic flag_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic push_word(logic [bscf_pkg::MODE_W-1:0] mode, logic [bscf_pkg::POS_W-1:0] pos,
                           bit exact, bscf_pkg::result_t want);
    int                gap;
    bscf_pkg::result_t pred;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.position <= pos;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_bitmap_op(mode, pos);
    pending_results.push_back(exact ? want : pred);
  endtask

  task automatic apb_xfer(logic wr, logic [bscf_pkg::CFG_DW-1:0] wdata,
                          output logic [bscf_pkg::CFG_DW-1:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= BITS_IN_USE_ADDR;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_span(logic [bscf_pkg::IDX_W-1:0] span, bit junk_upper);
    logic [bscf_pkg::CFG_DW-1:0] wdata;
    logic [bscf_pkg::CFG_DW-1:0] rdata;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    wdata = junk_upper ? bscf_pkg::CFG_DW'($urandom) : '0;
    wdata[bscf_pkg::IDX_W-1:0] = span;
    apb_xfer(1'b1, wdata, rdata);
    span_reg = span;
    apb_xfer(1'b0, '0, rdata);
    if (rdata[bscf_pkg::IDX_W-1:0] !== span)
      flag_mismatch("bits_in_use readback", span, rdata[bscf_pkg::IDX_W-1:0]);
  endtask

  task automatic pick_request(output logic [bscf_pkg::MODE_W-1:0] mode,
                              output logic [bscf_pkg::POS_W-1:0] pos);
    int r;
    int n;
    int hit;
    r    = $urandom_range(0, 99);
    n    = covered_len();
    n    = (n == 0) ? bscf_pkg::TOTAL_BITS : n;
    mode = bscf_pkg::MODE_TEST;
    pos  = bscf_pkg::POS_W'($urandom_range(0, n - 1));
    if (r < 8) begin
      // noise: any mode, any position
      mode = bscf_pkg::MODE_W'($urandom_range(0, 7));
      pos  = bscf_pkg::POS_W'($urandom);
    end else if (r < 38) begin
      mode = bscf_pkg::MODE_FIND_ZERO;
      pos  = bscf_pkg::POS_W'($urandom);
    end else if (r < 48) begin
      mode = bscf_pkg::MODE_FIND_ONE;
      pos  = bscf_pkg::POS_W'($urandom);
    end else if (r < 58) begin
      mode = bscf_pkg::MODE_TEST;
    end else if (draining) begin
      if (r < 85) begin
        mode = bscf_pkg::MODE_CLEAR;
        hit  = lowest_match(1'b1);
        if (hit >= 0) pos = bscf_pkg::POS_W'(hit);
      end else begin
        mode = bscf_pkg::MODE_SET;
      end
    end else begin
      if (r < 82) begin
        // allocate the lowest free position
        mode = bscf_pkg::MODE_SET;
        hit  = lowest_match(1'b0);
        if (hit >= 0) pos = bscf_pkg::POS_W'(hit);
      end else begin
        mode = bscf_pkg::MODE_CLEAR;
      end
    end
  endtask

  // result side: random ready with one long hold on request
  initial begin
    int hold_left;
    int holds_taken;
    hold_left    = 0;
    holds_taken  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (long_hold_reqs > holds_taken) begin
        holds_taken++;
        hold_left     = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        hold_left = pick_gap(recv_idle);
        if (hold_left > 0) begin
          out_ch.ready <= 1'b0;
          hold_left--;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    bscf_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word, found_index", 0, out_ch.found_index);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.bit_value !== want.bit_value)
          flag_mismatch("bit_value", want.bit_value, out_ch.bit_value);
        if (out_ch.found_index !== want.found_index)
          flag_mismatch("found_index", want.found_index, out_ch.found_index);
        if (out_ch.found !== want.found)
          flag_mismatch("found", want.found, out_ch.found);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [bscf_pkg::MODE_W-1:0] mode;
    logic [bscf_pkg::POS_W-1:0]  pos;
    logic [bscf_pkg::IDX_W-1:0]  span;
    bscf_pkg::result_t           want;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = '0;
    in_ch.position = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    send_idle      = 1'b1;
    recv_idle      = 1'b1;
    draining       = 1'b0;
    span_reg       = bscf_pkg::BITS_IN_USE_RST;
    foreach (bmap_words[i]) bmap_words[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        program_span(dir_rows[i].span, 1'b0);
      end else begin
        want = '{dir_rows[i].want_bit, dir_rows[i].want_idx, dir_rows[i].want_found};
        push_word(dir_rows[i].mode, dir_rows[i].pos, dir_rows[i].exact, want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:  span = 13'd4096;
        1:  span = 13'd1;
        2:  span = 13'd64;
        3:  span = 13'd65;
        4:  span = 13'd0;
        5:  span = 13'd130;
        6:  span = 13'd8191;
        7:  span = 13'd4095;
        8:  span = bscf_pkg::IDX_W'($urandom_range(1, 300));
        9:  span = bscf_pkg::IDX_W'($urandom_range(1, 4096));
        10: span = bscf_pkg::IDX_W'($urandom_range(4097, 8191));
        default: span = 13'd127;
      endcase
      program_span(span, ph >= 8);
      draining  = ph[0];
      send_idle = (ph % 4) != 1;
      recv_idle = (ph % 3) != 2;
      if (ph == 3) long_hold_reqs++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_request(mode, pos);
        push_word(mode, pos, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: bitmap_set_clear_find_first.f
rtl/bscf_pkg.sv
rtl/bscf_in_if.sv
rtl/bscf_out_if.sv
rtl/bscf_ram.sv
rtl/bscf_word_find.sv
rtl/bitmap_set_clear_find_first.sv
tb/bitmap_set_clear_find_first_tb.sv
